// ===== rtl/cwsig_pkg.sv =====
// shared types and constants for the convolution window index generator
`timescale 1ns / 1ps

package cwsig_pkg;

   localparam int BATCH_SIZE = 16;
   localparam int MAX_KERNEL = 8;
   localparam int MAX_DIM    = 256;

   localparam int DIM_W    = 9;
   localparam int KSZ_W    = 4;
   localparam int STRIDE_W = 4;
   localparam int PAD_W    = 3;
   localparam int POS_W    = 8;
   localparam int INDEX_W  = 16;
   localparam int BATCH_W  = 6;
   localparam int SLOT_W   = 6;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 9;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   localparam int KCNT_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int PROD_W = POS_W + STRIDE_W;
   localparam int BASE_W = PROD_W + 2;

   localparam logic [CSR_IDX_W-1:0] REG_INPUT_HEIGHT  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_WIDTH   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_HEIGHT = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_WIDTH  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE_ROWS   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE_COLS   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_ROWS      = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_COLS      = 4'd7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BASE,
      ST_BOUND,
      ST_WALK
   } state_type;

   // effective (saturated) layer setup
   typedef struct packed {
      logic [DIM_W-1:0]    input_height;
      logic [DIM_W-1:0]    input_width;
      logic [KSZ_W-1:0]    kernel_height;
      logic [KSZ_W-1:0]    kernel_width;
      logic [STRIDE_W-1:0] stride_rows;
      logic [STRIDE_W-1:0] stride_cols;
      logic [PAD_W-1:0]    pad_rows;
      logic [PAD_W-1:0]    pad_cols;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic base;
      logic bound;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic last;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/cwsig_csr.sv =====
// configuration registers with saturation of sizes
`timescale 1ns / 1ps

module cwsig_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cwsig_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cwsig_pkg::CSR_DATA_W-1:0]  csr_data,
   output cwsig_pkg::cfg_type                cfg
);
   import cwsig_pkg::*;

   logic [DIM_W-1:0]    input_height_ff, input_height_in;
   logic [DIM_W-1:0]    input_width_ff, input_width_in;
   logic [KSZ_W-1:0]    kernel_height_ff, kernel_height_in;
   logic [KSZ_W-1:0]    kernel_width_ff, kernel_width_in;
   logic [STRIDE_W-1:0] stride_rows_ff, stride_rows_in;
   logic [STRIDE_W-1:0] stride_cols_ff, stride_cols_in;
   logic [PAD_W-1:0]    pad_rows_ff, pad_rows_in;
   logic [PAD_W-1:0]    pad_cols_ff, pad_cols_in;
   logic                wr;

   assign csr_ready = 1'b1;
   assign wr = csr_valid & csr_ready;

   always_comb begin
      input_height_in  = input_height_ff;
      input_width_in   = input_width_ff;
      kernel_height_in = kernel_height_ff;
      kernel_width_in  = kernel_width_ff;
      stride_rows_in   = stride_rows_ff;
      stride_cols_in   = stride_cols_ff;
      pad_rows_in      = pad_rows_ff;
      pad_cols_in      = pad_cols_ff;
      if (wr) begin
         unique case (csr_index)
            REG_INPUT_HEIGHT:  input_height_in  = csr_data[DIM_W-1:0];
            REG_INPUT_WIDTH:   input_width_in   = csr_data[DIM_W-1:0];
            REG_KERNEL_HEIGHT: kernel_height_in = csr_data[KSZ_W-1:0];
            REG_KERNEL_WIDTH:  kernel_width_in  = csr_data[KSZ_W-1:0];
            REG_STRIDE_ROWS:   stride_rows_in   = csr_data[STRIDE_W-1:0];
            REG_STRIDE_COLS:   stride_cols_in   = csr_data[STRIDE_W-1:0];
            REG_PAD_ROWS:      pad_rows_in      = csr_data[PAD_W-1:0];
            REG_PAD_COLS:      pad_cols_in      = csr_data[PAD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         input_height_ff  <= DIM_W'(1);
         input_width_ff   <= DIM_W'(1);
         kernel_height_ff <= KSZ_W'(1);
         kernel_width_ff  <= KSZ_W'(1);
         stride_rows_ff   <= STRIDE_W'(1);
         stride_cols_ff   <= STRIDE_W'(1);
         pad_rows_ff      <= '0;
         pad_cols_ff      <= '0;
      end else begin
         input_height_ff  <= input_height_in;
         input_width_ff   <= input_width_in;
         kernel_height_ff <= kernel_height_in;
         kernel_width_ff  <= kernel_width_in;
         stride_rows_ff   <= stride_rows_in;
         stride_cols_ff   <= stride_cols_in;
         pad_rows_ff      <= pad_rows_in;
         pad_cols_ff      <= pad_cols_in;
      end
   end

   always_comb begin
      cfg.input_height  = (input_height_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                              : input_height_ff;
      cfg.input_width   = (input_width_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                             : input_width_ff;
      cfg.kernel_height = (kernel_height_ff > KSZ_W'(MAX_KERNEL)) ? KSZ_W'(MAX_KERNEL)
                                                                  : kernel_height_ff;
      cfg.kernel_width  = (kernel_width_ff > KSZ_W'(MAX_KERNEL)) ? KSZ_W'(MAX_KERNEL)
                                                                 : kernel_width_ff;
      cfg.stride_rows   = stride_rows_ff;
      cfg.stride_cols   = stride_cols_ff;
      cfg.pad_rows      = pad_rows_ff;
      cfg.pad_cols      = pad_cols_ff;
   end

endmodule

// ===== rtl/cwsig_ctrl.sv =====
// sequencing state machine for the window walk
`timescale 1ns / 1ps

module cwsig_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  cwsig_pkg::status_type status,
   output cwsig_pkg::cmd_type    cmd
);
   import cwsig_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_BASE;
         ST_BASE:  state_in = ST_BOUND;
         ST_BOUND: state_in = ST_WALK;
         ST_WALK: begin
            if (status.empty) state_in = ST_IDLE;
            else if (status.out_free && status.last) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_BASE:  cmd.base  = 1'b1;
         ST_BOUND: cmd.bound = 1'b1;
         ST_WALK:  cmd.step  = !status.empty && status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/cwsig_dp.sv =====
// window bounds, coordinate walk, index arithmetic and result register
`timescale 1ns / 1ps

module cwsig_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  cwsig_pkg::cfg_type                cfg,
   input  cwsig_pkg::cmd_type                cmd,
   output cwsig_pkg::status_type             status,
   input  logic [cwsig_pkg::POS_W-1:0]       out_row,
   input  logic [cwsig_pkg::POS_W-1:0]       out_col,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cwsig_pkg::INDEX_W-1:0]     spine_index,
   output logic [cwsig_pkg::BATCH_W-1:0]     batch_number,
   output logic [cwsig_pkg::SLOT_W-1:0]      slot_in_batch,
   output logic                              batch_end,
   output logic                              run_end
);
   import cwsig_pkg::*;

   logic [POS_W-1:0]         held_row_ff, held_col_ff;
   logic signed [BASE_W-1:0] base_row_ff, base_col_ff;
   logic signed [BASE_W-1:0] base_row_in, base_col_in;
   logic [PROD_W-1:0]        row_prod, col_prod;

   logic signed [BASE_W-1:0] lo_r_s, lo_c_s, hi_r_k, hi_r_d, hi_c_k, hi_c_d;
   logic signed [BASE_W-1:0] hi_r_s, hi_c_s;
   logic [KCNT_W-1:0]        lo_r, lo_c;
   logic                     empty_in;

   logic [KCNT_W-1:0]        r_lo_ff, r_hi_ff, c_lo_ff, c_hi_ff;
   logic [KCNT_W-1:0]        r_ff, c_ff;
   logic [POS_W-1:0]         hr_ff, wc_ff, wc_start_ff;
   logic                     empty_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic [BATCH_W-1:0]       batch_ff;
   logic                     last_pos, slot_wrap;
   logic [POS_W+DIM_W-1:0]   index_sum;

   logic                     rsp_valid_ff;
   logic [INDEX_W-1:0]       index_ff;
   logic [BATCH_W-1:0]       rsp_batch_ff;
   logic [SLOT_W-1:0]        rsp_slot_ff;
   logic                     batch_end_ff, run_end_ff;

   // window origin in input coordinates
   assign row_prod    = PROD_W'(held_row_ff) * PROD_W'(cfg.stride_rows);
   assign col_prod    = PROD_W'(held_col_ff) * PROD_W'(cfg.stride_cols);
   assign base_row_in = BASE_W'(row_prod) - BASE_W'(cfg.pad_rows);
   assign base_col_in = BASE_W'(col_prod) - BASE_W'(cfg.pad_cols);

   // valid kernel offsets form a rectangle
   assign lo_r   = base_row_ff[BASE_W-1] ? KCNT_W'(BASE_W'(0) - base_row_ff) : '0;
   assign lo_c   = base_col_ff[BASE_W-1] ? KCNT_W'(BASE_W'(0) - base_col_ff) : '0;
   assign lo_r_s = BASE_W'(lo_r);
   assign lo_c_s = BASE_W'(lo_c);
   assign hi_r_k = BASE_W'(cfg.kernel_height) - BASE_W'(1);
   assign hi_c_k = BASE_W'(cfg.kernel_width) - BASE_W'(1);
   assign hi_r_d = BASE_W'(cfg.input_height) - BASE_W'(1) - base_row_ff;
   assign hi_c_d = BASE_W'(cfg.input_width) - BASE_W'(1) - base_col_ff;
   assign hi_r_s = (hi_r_k < hi_r_d) ? hi_r_k : hi_r_d;
   assign hi_c_s = (hi_c_k < hi_c_d) ? hi_c_k : hi_c_d;
   assign empty_in = (hi_r_s < lo_r_s) || (hi_c_s < lo_c_s);

   assign last_pos  = (r_ff == r_hi_ff) && (c_ff == c_hi_ff);
   assign slot_wrap = (slot_ff == SLOT_W'(BATCH_SIZE - 1));
   assign index_sum = (POS_W+DIM_W)'(hr_ff) * (POS_W+DIM_W)'(cfg.input_width)
                      + (POS_W+DIM_W)'(wc_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         held_row_ff <= out_row;
         held_col_ff <= out_col;
      end
      if (cmd.base) begin
         base_row_ff <= base_row_in;
         base_col_ff <= base_col_in;
      end
      if (cmd.bound) begin
         r_lo_ff     <= lo_r;
         c_lo_ff     <= lo_c;
         r_hi_ff     <= KCNT_W'(hi_r_s);
         c_hi_ff     <= KCNT_W'(hi_c_s);
         r_ff        <= lo_r;
         c_ff        <= lo_c;
         hr_ff       <= base_row_ff[BASE_W-1] ? '0 : POS_W'(base_row_ff);
         wc_ff       <= base_col_ff[BASE_W-1] ? '0 : POS_W'(base_col_ff);
         wc_start_ff <= base_col_ff[BASE_W-1] ? '0 : POS_W'(base_col_ff);
         slot_ff     <= '0;
         batch_ff    <= '0;
      end else if (cmd.step) begin
         if (c_ff == c_hi_ff) begin
            c_ff  <= c_lo_ff;
            wc_ff <= wc_start_ff;
            r_ff  <= r_ff + KCNT_W'(1);
            hr_ff <= hr_ff + POS_W'(1);
         end else begin
            c_ff  <= c_ff + KCNT_W'(1);
            wc_ff <= wc_ff + POS_W'(1);
         end
         if (slot_wrap) begin
            slot_ff  <= '0;
            batch_ff <= batch_ff + BATCH_W'(1);
         end else begin
            slot_ff <= slot_ff + SLOT_W'(1);
         end
      end
      if (cmd.step) begin
         index_ff     <= INDEX_W'(index_sum);
         rsp_batch_ff <= batch_ff;
         rsp_slot_ff  <= slot_ff;
         batch_end_ff <= last_pos || slot_wrap;
         run_end_ff   <= last_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.bound) empty_ff <= empty_in;
         if (cmd.step) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign status.empty    = empty_ff;
   assign status.last     = last_pos;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign spine_index   = index_ff;
   assign batch_number  = rsp_batch_ff;
   assign slot_in_batch = rsp_slot_ff;
   assign batch_end     = batch_end_ff;
   assign run_end       = run_end_ff;

   a_step_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while stalled");

   a_walk_inside_window: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (r_ff <= r_hi_ff) && (r_ff >= r_lo_ff)
                   && (c_ff <= c_hi_ff) && (c_ff >= c_lo_ff))
      else $error("walk left the valid window");

   a_run_end_marks_batch_end: assert property (@(posedge clock) disable iff (reset)
      cmd.step && last_pos |=> rsp_valid_ff && run_end_ff && batch_end_ff)
      else $error("last result of a run not closing its batch");

   a_no_step_when_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !empty_ff)
      else $error("result issued for an empty window");

endmodule

// ===== rtl/conv_window_spine_id_generator.sv =====
// top level of the convolution window index generator
`timescale 1ns / 1ps

// Takes one output position per transaction and returns the flat input indices
// of its kernel window that fall inside the input map, row-major, one per cycle
// while rsp_tready does not stall. An item first goes through setup (capture,
// window origin, window bounds), then the walk, which issues one index per valid
// position; a window wholly in the padding gives no result (the setup plus one
// walk step that finds the window empty). The walk unit visits only in-range
// positions, so the cost is set by the count of valid indices and by
// back-pressure on rsp_tready. A new position is taken once the last index of
// the previous one sits in the result register.
module conv_window_spine_id_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cwsig_pkg::REQ_DATA_W-1:0]  req_tdata,  // out_row, out_col
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cwsig_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // spine_index, batch_number,
                                                         // slot_in_batch, zero fill
   output logic                              rsp_tuser,  // batch_end
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cwsig_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cwsig_pkg::CSR_DATA_W-1:0]  csr_data
);
   import cwsig_pkg::*;

   cfg_type            cfg;
   cmd_type            cmd;
   status_type         status;
   logic [INDEX_W-1:0] spine_index;
   logic [BATCH_W-1:0] batch_number;
   logic [SLOT_W-1:0]  slot_in_batch;

   cwsig_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cwsig_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cwsig_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .status        (status),
      .out_row       (req_tdata[POS_W-1:0]),
      .out_col       (req_tdata[2*POS_W-1:POS_W]),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .spine_index   (spine_index),
      .batch_number  (batch_number),
      .slot_in_batch (slot_in_batch),
      .batch_end     (rsp_tuser),
      .run_end       (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W-INDEX_W-BATCH_W-SLOT_W)'(0),
                       slot_in_batch, batch_number, spine_index};

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the convolution window index generator: directed table, then random layer setups
`timescale 1ns / 1ps

module tb_top;
   import cwsig_pkg::*;

   localparam int CYCLE_LIMIT     = 5_000_000;
   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 20;
   localparam int RAND_PHASES     = 8;
   localparam int ITEMS_PER_PHASE = 20;
   localparam int N_STEPS         = 43;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 4'd12;

   typedef struct packed {
      logic [INDEX_W-1:0] spine_index;
      logic [BATCH_W-1:0] batch_number;
      logic [SLOT_W-1:0]  slot_in_batch;
      logic               batch_end;
      logic               run_end;
   } window_hit_type;

   typedef enum logic [1:0] {
      STEP_CFG,
      STEP_POS,
      STEP_EMPTY,
      STEP_ONE
   } step_kind_type;

   typedef struct packed {
      step_kind_type        kind;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [DIM_W-1:0]     value;
      logic [POS_W-1:0]     row;
      logic [POS_W-1:0]     col;
      logic [INDEX_W-1:0]   one_index;
   } script_step_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   cfg_type        layer_cfg;
   window_hit_type expected_hits[$];
   window_hit_type got_hit;
   window_hit_type want_hit;
   int             error_count = 0;
   bit             calm = 1'b0;
   bit             long_hold_pending = 1'b0;

   // row, column and single-result expectations typed only where obvious
   script_step_type directed_steps [N_STEPS] = '{
      '{STEP_ONE,   4'd0,              9'd0,   8'd0,   8'd0,   16'd0},
      '{STEP_EMPTY, 4'd0,              9'd0,   8'd255, 8'd255, 16'd0},
      '{STEP_EMPTY, 4'd0,              9'd0,   8'd0,   8'd1,   16'd0},
      '{STEP_EMPTY, 4'd0,              9'd0,   8'd1,   8'd0,   16'd0},
      '{STEP_CFG,   REG_INPUT_HEIGHT,  9'h1FF, 8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_INPUT_WIDTH,   9'd256, 8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_KERNEL_HEIGHT, 9'd15,  8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_KERNEL_WIDTH,  9'd8,   8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_PAD_ROWS,      9'd7,   8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_PAD_COLS,      9'd7,   8'd0,   8'd0,   16'd0},
      '{STEP_ONE,   4'd0,              9'd0,   8'd0,   8'd0,   16'd0},
      '{STEP_POS,   4'd0,              9'd0,   8'd3,   8'd3,   16'd0},
      '{STEP_POS,   4'd0,              9'd0,   8'd4,   8'd3,   16'd0},
      '{STEP_POS,   4'd0,              9'd0,   8'd100, 8'd100, 16'd0},
      '{STEP_POS,   4'd0,              9'd0,   8'd255, 8'd255, 16'd0},
      '{STEP_CFG,   REG_KERNEL_HEIGHT, 9'd0,   8'd0,   8'd0,   16'd0},
      '{STEP_EMPTY, 4'd0,              9'd0,   8'd100, 8'd100, 16'd0},
      '{STEP_CFG,   REG_KERNEL_HEIGHT, 9'd8,   8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_INPUT_HEIGHT,  9'd0,   8'd0,   8'd0,   16'd0},
      '{STEP_EMPTY, 4'd0,              9'd0,   8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_INPUT_HEIGHT,  9'd20,  8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_INPUT_WIDTH,   9'h1FF, 8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_KERNEL_WIDTH,  9'd1,   8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_STRIDE_ROWS,   9'd0,   8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_STRIDE_COLS,   9'd15,  8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_PAD_ROWS,      9'd0,   8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_PAD_COLS,      9'd0,   8'd0,   8'd0,   16'd0},
      '{STEP_POS,   4'd0,              9'd0,   8'd200, 8'd0,   16'd0},
      '{STEP_POS,   4'd0,              9'd0,   8'd7,   8'd17,  16'd0},
      '{STEP_CFG,   REG_UNUSED,        9'h1FF, 8'd0,   8'd0,   16'd0},
      '{STEP_POS,   4'd0,              9'd0,   8'd0,   8'd16,  16'd0},
      '{STEP_CFG,   REG_INPUT_HEIGHT,  9'd16,  8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_INPUT_WIDTH,   9'd16,  8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_KERNEL_HEIGHT, 9'd3,   8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_KERNEL_WIDTH,  9'd3,   8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_STRIDE_ROWS,   9'd8,   8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_STRIDE_COLS,   9'd8,   8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_PAD_ROWS,      9'd1,   8'd0,   8'd0,   16'd0},
      '{STEP_CFG,   REG_PAD_COLS,      9'd1,   8'd0,   8'd0,   16'd0},
      '{STEP_POS,   4'd0,              9'd0,   8'd0,   8'd0,   16'd0},
      '{STEP_POS,   4'd0,              9'd0,   8'd1,   8'd1,   16'd0},
      '{STEP_ONE,   4'd0,              9'd0,   8'd2,   8'd2,   16'd255},
      '{STEP_EMPTY, 4'd0,              9'd0,   8'd3,   8'd3,   16'd0}
   };

   conv_window_spine_id_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // append to the tail of the expected queue
   function automatic void queue_hit(input window_hit_type h);
      expected_hits.insert(expected_hits.size(), h);
   endfunction

   // expected indices of one window under the current layer setup
   function automatic void predict_window(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c);
      int kh, kw, ih, iw, base_r, base_c, hr, wc, n, kr, kc, k;
      logic [INDEX_W-1:0] idx_list[$];
      window_hit_type hit;
      kh = (layer_cfg.kernel_height > MAX_KERNEL) ? MAX_KERNEL : int'(layer_cfg.kernel_height);
      kw = (layer_cfg.kernel_width > MAX_KERNEL) ? MAX_KERNEL : int'(layer_cfg.kernel_width);
      ih = (layer_cfg.input_height > MAX_DIM) ? MAX_DIM : int'(layer_cfg.input_height);
      iw = (layer_cfg.input_width > MAX_DIM) ? MAX_DIM : int'(layer_cfg.input_width);
      base_r = int'(r) * int'(layer_cfg.stride_rows) - int'(layer_cfg.pad_rows);
      base_c = int'(c) * int'(layer_cfg.stride_cols) - int'(layer_cfg.pad_cols);
      for (kr = 0; kr < kh; kr++) begin
         for (kc = 0; kc < kw; kc++) begin
            hr = base_r + kr;
            wc = base_c + kc;
            if (hr < 0 || hr >= ih || wc < 0 || wc >= iw) continue;
            idx_list.insert(idx_list.size(), INDEX_W'(hr * iw + wc));
         end
      end
      n = idx_list.size();
      for (k = 0; k < n; k++) begin
         hit.spine_index   = idx_list[k];
         hit.batch_number  = BATCH_W'(k / BATCH_SIZE);
         hit.slot_in_batch = SLOT_W'(k % BATCH_SIZE);
         hit.run_end       = (k == n - 1);
         hit.batch_end     = hit.run_end || (k % BATCH_SIZE == BATCH_SIZE - 1);
         queue_hit(hit);
      end
   endfunction

   // mostly positions whose window touches the map, some anywhere
   function automatic logic [POS_W-1:0] pick_coord(input int dim, input int stride, input int pad);
      int extent, lim;
      if ($urandom_range(0, 3) == 0) return POS_W'($urandom_range(0, 255));
      extent = (dim > MAX_DIM) ? MAX_DIM : dim;
      lim = (extent + pad) / ((stride == 0) ? 1 : stride);
      if (lim > 255) lim = 255;
      return POS_W'($urandom_range(0, lim));
   endfunction

   function automatic logic [DIM_W-1:0] rand_dim();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return '0;
      if (roll == 1) return DIM_W'($urandom_range(256, 511));
      return DIM_W'($urandom_range(1, 24));
   endfunction

   function automatic logic [DIM_W-1:0] rand_kernel();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return '0;
      if (roll == 1) return DIM_W'($urandom_range(9, 15));
      return DIM_W'($urandom_range(1, 8));
   endfunction

   function automatic logic [DIM_W-1:0] rand_stride();
      if ($urandom_range(0, 9) == 0) return DIM_W'($urandom_range(0, 15));
      return DIM_W'($urandom_range(1, 3));
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_INPUT_HEIGHT:  layer_cfg.input_height  = val;
         REG_INPUT_WIDTH:   layer_cfg.input_width   = val;
         REG_KERNEL_HEIGHT: layer_cfg.kernel_height = val[KSZ_W-1:0];
         REG_KERNEL_WIDTH:  layer_cfg.kernel_width  = val[KSZ_W-1:0];
         REG_STRIDE_ROWS:   layer_cfg.stride_rows   = val[STRIDE_W-1:0];
         REG_STRIDE_COLS:   layer_cfg.stride_cols   = val[STRIDE_W-1:0];
         REG_PAD_ROWS:      layer_cfg.pad_rows      = val[PAD_W-1:0];
         REG_PAD_COLS:      layer_cfg.pad_cols      = val[PAD_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic quiesce();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (expected_hits.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic offer_pos(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c);
      req_tdata  <= {c, r};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic sender_gap();
      int gap;
      @(negedge clock);
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // result side
   initial begin
      int stall_left;
      int hold_count;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            hold_count = 0;
            while (hold_count < HOLD_CYCLES) begin
               @(negedge clock);
               hold_count++;
            end
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_hit.spine_index   = rsp_tdata[INDEX_W-1:0];
         got_hit.batch_number  = rsp_tdata[INDEX_W +: BATCH_W];
         got_hit.slot_in_batch = rsp_tdata[INDEX_W+BATCH_W +: SLOT_W];
         got_hit.batch_end     = rsp_tuser;
         got_hit.run_end       = rsp_tlast;
         if (expected_hits.size() == 0) begin
            report_mismatch("unexpected transaction, spine_index", got_hit.spine_index, -1);
         end else begin
            want_hit = expected_hits.pop_front();
            if (got_hit.spine_index != want_hit.spine_index)
               report_mismatch("spine_index", got_hit.spine_index, want_hit.spine_index);
            if (got_hit.batch_number != want_hit.batch_number)
               report_mismatch("batch_number", got_hit.batch_number, want_hit.batch_number);
            if (got_hit.slot_in_batch != want_hit.slot_in_batch)
               report_mismatch("slot_in_batch", got_hit.slot_in_batch, want_hit.slot_in_batch);
            if (got_hit.batch_end != want_hit.batch_end)
               report_mismatch("batch_end", got_hit.batch_end, want_hit.batch_end);
            if (got_hit.run_end != want_hit.run_end)
               report_mismatch("run_end", got_hit.run_end, want_hit.run_end);
         end
      end
   end

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      script_step_type  st;
      logic [POS_W-1:0] r;
      logic [POS_W-1:0] c;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      layer_cfg  = '{input_height: 1, input_width: 1, kernel_height: 1, kernel_width: 1,
                     stride_rows: 1, stride_cols: 1, pad_rows: 0, pad_cols: 0};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < N_STEPS; i++) begin
         st = directed_steps[i];
         if (st.kind == STEP_CFG) begin
            if (!csr_valid) quiesce();
            write_reg(st.reg_idx, st.value);
         end else begin
            if (csr_valid) csr_valid <= 1'b0;
            offer_pos(st.row, st.col);
            case (st.kind)
               STEP_ONE:   queue_hit('{st.one_index, '0, '0, 1'b1, 1'b1});
               STEP_EMPTY: ;
               default:    predict_window(st.row, st.col);
            endcase
            sender_gap();
         end
      end

      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         quiesce();
         calm = (phase % 4 == 3);
         write_reg(REG_INPUT_HEIGHT, rand_dim());
         write_reg(REG_INPUT_WIDTH, rand_dim());
         write_reg(REG_KERNEL_HEIGHT, rand_kernel());
         write_reg(REG_KERNEL_WIDTH, rand_kernel());
         write_reg(REG_STRIDE_ROWS, rand_stride());
         write_reg(REG_STRIDE_COLS, rand_stride());
         write_reg(REG_PAD_ROWS, CSR_DATA_W'($urandom_range(0, 7)));
         write_reg(REG_PAD_COLS, CSR_DATA_W'($urandom_range(0, 7)));
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_IDX_W'($urandom_range(8, 15)), CSR_DATA_W'($urandom_range(0, 511)));
         csr_valid <= 1'b0;
         // the result side holds off while items keep coming
         if (phase == 1) long_hold_pending = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            r = pick_coord(layer_cfg.input_height, layer_cfg.stride_rows, layer_cfg.pad_rows);
            c = pick_coord(layer_cfg.input_width, layer_cfg.stride_cols, layer_cfg.pad_cols);
            offer_pos(r, c);
            predict_window(r, c);
            sender_gap();
         end
      end

      if (req_tvalid) req_tvalid <= 1'b0;
      while (expected_hits.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/cwsig_pkg.sv
rtl/cwsig_csr.sv
rtl/cwsig_ctrl.sv
rtl/cwsig_dp.sv
rtl/conv_window_spine_id_generator.sv
tb/sv/tb_top.sv
